// ----- rtl/b64sd_pkg.sv -----
package b64sd_pkg;

	localparam int QDepth = 8;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);
	localparam int MaxRes = 4;

	localparam logic [1:0] ST_DATA = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	// map one character of the standard alphabet; '=' maps to zero
	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r = '{ok: 1'b1, val: 6'd0};
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r.val = 6'(c - CH_UPPER_A);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			r.val = 6'(c - CH_LOWER_A) + 6'd26;
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			r.val = 6'(c - CH_DIGIT_0) + 6'd52;
		end else if (c == CH_PLUS) begin
			r.val = 6'd62;
		end else if (c == CH_SLASH) begin
			r.val = 6'd63;
		end else if (c == CH_PAD) begin
			r.val = 6'd0;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- rtl/base64_stream_decoder.sv -----
// Results of an accepted character go to the result queue and leave after older ones.
// One character per cycle unless stalled; one result word per cycle unless out_stall.
// A character sits in the input register until the 8-entry result queue has room for
// the four results it can cause, so input stalls only while more than four wait.
// Reset (arst_n low, asynchronous) empties the queue and clears the group and error state.
module base64_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       in_final,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] out_status,
	output logic       out_last
);

	logic                           vld_s1;
	logic [7:0]                     char_s1;
	logic                           final_s1;

	logic [17:0]                    acc_q;
	logic [1:0]                     pos_q;
	logic [2:0]                     pad_q;
	logic                           err_q;

	b64sd_pkg::res_t                q_mem [b64sd_pkg::QDepth];
	logic [b64sd_pkg::QPtrW-1:0]    wr_ptr_q;
	logic [b64sd_pkg::QPtrW-1:0]    rd_ptr_q;
	logic [b64sd_pkg::QCntW-1:0]    cnt_q;

	logic                           room;
	logic                           take;
	logic                           pop;
	b64sd_pkg::sextet_t             sx;
	logic                           is_pad;
	logic [2:0]                     pad_n;
	logic [23:0]                    word;
	logic [1:0]                     nbytes;
	logic [2:0]                     nres;
	b64sd_pkg::res_t                res [b64sd_pkg::MaxRes];
	logic [17:0]                    acc_d;
	logic [1:0]                     pos_d;
	logic [2:0]                     pad_d;
	logic                           err_d;
	logic [1:0]                     pos_after;
	logic [7:0]                     bytes [3];

	// hold the character until the queue can absorb a full burst of results
	assign room     = cnt_q <= b64sd_pkg::QCntW'(b64sd_pkg::QDepth - b64sd_pkg::MaxRes);
	assign take     = vld_s1 && room;
	assign in_stall = vld_s1 && !room;
	assign pop      = out_valid && !out_stall;

	assign sx     = b64sd_pkg::sextet_of(char_s1);
	assign is_pad = char_s1 == b64sd_pkg::CH_PAD;
	assign pad_n  = pad_q + {2'b00, is_pad};
	assign word   = {acc_q, sx.val};

	assign bytes[0] = word[23:16];
	assign bytes[1] = word[15:8];
	assign bytes[2] = word[7:0];

	always_comb begin
		acc_d     = acc_q;
		pos_d     = pos_q;
		pad_d     = pad_q;
		err_d     = err_q;
		nbytes    = 2'd0;
		nres      = 3'd0;
		pos_after = pos_q;
		for (int j = 0; j < b64sd_pkg::MaxRes; j++) begin
			res[j] = '{data: 8'd0, status: b64sd_pkg::ST_DATA, last: 1'b0};
		end
		if (err_q) begin
			// drop the rest of the string
			if (final_s1) begin
				acc_d = '0;
				pos_d = '0;
				pad_d = '0;
				err_d = 1'b0;
			end
		end else if (!sx.ok) begin
			res[0] = '{data: 8'd0, status: b64sd_pkg::ST_ERR, last: 1'b1};
			nres   = 3'd1;
			acc_d  = '0;
			pos_d  = '0;
			pad_d  = '0;
			err_d  = !final_s1;
		end else begin
			if (pos_q == 2'd3) begin
				nbytes    = (pad_n >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_n);
				pos_after = 2'd0;
				acc_d     = '0;
				pos_d     = '0;
				pad_d     = '0;
			end else begin
				pos_after = pos_q + 2'd1;
				acc_d     = {acc_q[11:0], sx.val};
				pos_d     = pos_after;
				pad_d     = pad_n;
			end
			for (int j = 0; j < 3; j++) begin
				if (2'(j) < nbytes) begin
					res[j] = '{data: bytes[j], status: b64sd_pkg::ST_DATA, last: 1'b0};
				end
			end
			nres = {1'b0, nbytes};
			if (final_s1) begin
				res[nbytes] = '{data: 8'd0,
					status: (pos_after != 2'd0) ? b64sd_pkg::ST_ERR : b64sd_pkg::ST_OK,
					last: 1'b1};
				nres  = {1'b0, nbytes} + 3'd1;
				acc_d = '0;
				pos_d = '0;
				pad_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1  <= in_char;
			final_s1 <= in_final;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			pad_q <= '0;
			err_q <= 1'b0;
		end else if (take) begin
			acc_q <= acc_d;
			pos_q <= pos_d;
			pad_q <= pad_d;
			err_q <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < b64sd_pkg::MaxRes; j++) begin
				if (3'(j) < nres) begin
					q_mem[wr_ptr_q + b64sd_pkg::QPtrW'(j)] <= res[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= wr_ptr_q + b64sd_pkg::QPtrW'(nres);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + b64sd_pkg::QPtrW'(1);
			end
			cnt_q <= cnt_q + (take ? b64sd_pkg::QCntW'(nres) : '0)
				- b64sd_pkg::QCntW'(pop);
		end
	end

	assign out_valid  = cnt_q != '0;
	assign out_byte   = q_mem[rd_ptr_q].data;
	assign out_status = q_mem[rd_ptr_q].status;
	assign out_last   = q_mem[rd_ptr_q].last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= b64sd_pkg::QCntW'(b64sd_pkg::QDepth))
		else $error("result queue overfilled");

	a_pad_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q <= {1'b0, pos_q})
		else $error("pad count exceeds characters in group");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1)
		else $error("input stalled with empty input register");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> cnt_q <= b64sd_pkg::QCntW'(b64sd_pkg::QDepth))
		else $error("push overran queue");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_last) |-> out_status != b64sd_pkg::ST_DATA)
		else $error("last word carries data status");

endmodule
